// File: rtl/hslrgb_pkg.sv
package hslrgb_pkg;

	localparam logic [15:0] HUE_THIRD    = 16'd21845;
	localparam logic [15:0] HUE_NTHIRD   = 16'd43691;
	localparam logic [15:0] HUE_SIXTH    = 16'd10923;
	localparam logic [15:0] HUE_HALF     = 16'd32768;
	localparam logic [15:0] HUE_TWOTHIRD = 16'd43691;
	localparam logic [16:0] ONE_Q16      = 17'h10000;
	localparam logic [15:0] CHAN_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [15:0] hue;
		logic [15:0] lightness;
		logic [15:0] saturation;
	} hsl_pixel_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb_pixel_t;

	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
	} chan_ctl_t;

	// piecewise-linear hue ramp factor, q1.16 with one at 65536
	function automatic logic [16:0] ramp_factor(input logic [15:0] t);
		logic [15:0] u;
		logic [18:0] six;
		logic [16:0] f;
		u = 16'd0;
		six = 19'd0;
		f = 17'd0;
		if (t < HUE_SIXTH) begin
			u = t;
			six = 19'({u, 2'b00}) + 19'({u, 1'b0});
			f = (six > 19'(ONE_Q16)) ? ONE_Q16 : six[16:0];
		end else if (t < HUE_HALF) begin
			f = ONE_Q16;
		end else if (t < HUE_TWOTHIRD) begin
			u = HUE_TWOTHIRD - t;
			six = 19'({u, 2'b00}) + 19'({u, 1'b0});
			f = (six > 19'(ONE_Q16)) ? ONE_Q16 : six[16:0];
		end else begin
			f = 17'd0;
		end
		return f;
	endfunction

endpackage

// File: rtl/hslrgb_chan.sv
module hslrgb_chan
	import hslrgb_pkg::*;
(
	input  logic        clk,
	input  chan_ctl_t   ctl,
	input  logic [32:0] d_s3,
	input  logic [31:0] p_s3,
	input  logic [16:0] f_s3,
	output logic [15:0] chan
);

	logic [49:0] prod_s4;
	logic [31:0] p_s4;
	logic [50:0] acc;
	logic [18:0] rnd;
	logic [15:0] chan_s5;

	// ramp scale: (q - p) * f in q2.48
	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			prod_s4 <= 50'(d_s3) * 50'(f_s3);
			p_s4 <= p_s3;
		end
	end

	// add p, round half up, saturate
	always_comb begin
		acc = 51'({p_s4, 16'h0000}) + 51'(prod_s4) + (51'd1 << 31);
		rnd = acc[50:32];
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			chan_s5 <= (rnd > 19'(CHAN_MAX)) ? CHAN_MAX : rnd[15:0];
		end
	end

	assign chan = chan_s5;

endmodule

// File: rtl/hsl_to_rgb_converter_core.sv
// hsl to rgb pixel converter
//
// input channel hsl_valid / hsl_ready / hsl carries one pixel per item:
// hue, lightness and saturation as unsigned q0.16 fractions, hue wrapping
// modulo one. output channel rgb_valid / rgb_ready / rgb carries red, green
// and blue as unsigned q0.16, rounded half up and saturated to 65535.
//
// five register stages: product l*s and hue ramp factors, q, p and q-p,
// three ramp multipliers, then add, round and saturate into the output
// register. an accepted item passes through the stages in order and shows
// on rgb with rgb_valid once it reaches stage five; throughput is one item
// per clock while rgb_ready does not hold the output.
//
// each stage holds only while the stage after it is full and stalled, so
// bubbles are squeezed out and hsl_ready drops only when all five stages
// hold items and rgb_ready is low. nothing is lost or repeated.
//
// arst_n clears all stage valid bits; the pipeline comes out of reset empty
// and ready.
module hsl_to_rgb_converter_core
	import hslrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hsl_valid,
	output logic       hsl_ready,
	input  hsl_pixel_t hsl,
	output logic       rgb_valid,
	input  logic       rgb_ready,
	output rgb_pixel_t rgb
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [15:0] l_s1, s_s1;
	logic [31:0] ls_s1;
	logic [16:0] fr_s1, fg_s1, fb_s1;

	logic [32:0] q_s2;
	logic [31:0] l32_s2;
	logic [16:0] fr_s2, fg_s2, fb_s2;

	logic [32:0] d_s3;
	logic [31:0] p_s3;
	logic [16:0] fr_s3, fg_s3, fb_s3;

	logic [32:0] l32x, s32x, lsx, q_nxt;
	logic [32:0] p_nxt, qd_nxt;
	chan_ctl_t   chan_ctl;

	// stage k moves when empty or when the next stage takes its item
	assign rdy5 = !v_s5 || rgb_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign hsl_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= hsl_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: l*s and hue ramp factors
	always_ff @(posedge clk) begin
		if (rdy1 && hsl_valid) begin
			l_s1  <= hsl.lightness;
			s_s1  <= hsl.saturation;
			ls_s1 <= 32'(hsl.lightness) * 32'(hsl.saturation);
			fr_s1 <= ramp_factor(hsl.hue + HUE_THIRD);
			fg_s1 <= ramp_factor(hsl.hue);
			fb_s1 <= ramp_factor(hsl.hue + HUE_NTHIRD);
		end
	end

	// stage 2: q
	always_comb begin
		l32x = {1'b0, l_s1, 16'h0000};
		s32x = {1'b0, s_s1, 16'h0000};
		lsx  = {1'b0, ls_s1};
		if (l_s1[15]) begin
			q_nxt = l32x + s32x - lsx;
		end else begin
			q_nxt = l32x + lsx;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			q_s2   <= q_nxt;
			l32_s2 <= {l_s1, 16'h0000};
			fr_s2  <= fr_s1;
			fg_s2  <= fg_s1;
			fb_s2  <= fb_s1;
		end
	end

	// stage 3: p = 2l - q and q - p = 2(q - l)
	always_comb begin
		p_nxt  = {l32_s2, 1'b0} - q_s2;
		qd_nxt = q_s2 - {1'b0, l32_s2};
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			p_s3  <= p_nxt[31:0];
			d_s3  <= {qd_nxt[31:0], 1'b0};
			fr_s3 <= fr_s2;
			fg_s3 <= fg_s2;
			fb_s3 <= fb_s2;
		end
	end

	// stages 4 and 5 in the channel units
	assign chan_ctl.ld_s4 = rdy4 && v_s3;
	assign chan_ctl.ld_s5 = rdy5 && v_s4;

	hslrgb_chan u_chan_red (
		.clk  (clk),
		.ctl  (chan_ctl),
		.d_s3 (d_s3),
		.p_s3 (p_s3),
		.f_s3 (fr_s3),
		.chan (rgb.red)
	);

	hslrgb_chan u_chan_green (
		.clk  (clk),
		.ctl  (chan_ctl),
		.d_s3 (d_s3),
		.p_s3 (p_s3),
		.f_s3 (fg_s3),
		.chan (rgb.green)
	);

	hslrgb_chan u_chan_blue (
		.clk  (clk),
		.ctl  (chan_ctl),
		.d_s3 (d_s3),
		.p_s3 (p_s3),
		.f_s3 (fb_s3),
		.chan (rgb.blue)
	);

	assign rgb_valid = v_s5;

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !rgb_ready))
		else $error("input stalled while pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(hsl_valid && hsl_ready) |=> v_s1)
		else $error("accepted item missing from stage 1");

	a_q_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((q_s2 >= {1'b0, l32_s2}) && (q_s2 <= {l32_s2, 1'b0})))
		else $error("q outside [l, 2l]");

	a_factor_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((fr_s1 <= ONE_Q16) && (fg_s1 <= ONE_Q16) && (fb_s1 <= ONE_Q16)))
		else $error("ramp factor above one");
`endif

endmodule
